[src/pidpmd_pkg.sv]
// ----------------------------------------------------------------------------
// pidpmd_pkg: shared types and constants of the position PID drive
// Register indexes, register widths, reset values and the settings bundle.
// ----------------------------------------------------------------------------
package pidpmd_pkg;

  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int MS_W       = 15;
  localparam int MAG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_OUT_LOWER  = 3'd3,
    CFG_OUT_UPPER  = 3'd4,
    CFG_MIN_SPEED  = 3'd5
  } cfg_idx_t;

  localparam logic signed [GAIN_W-1:0]  PROP_GAIN_RST  = 16'sd256;
  localparam logic signed [GAIN_W-1:0]  INTEG_GAIN_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0]  DERIV_GAIN_RST = 16'sd0;
  localparam logic signed [LIMIT_W-1:0] OUT_LOWER_RST  = -16'sd100;
  localparam logic signed [LIMIT_W-1:0] OUT_UPPER_RST  = 16'sd100;
  localparam logic [MS_W-1:0]           MIN_SPEED_RST  = 15'd0;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  prop_gain;
    logic signed [GAIN_W-1:0]  integ_gain;
    logic signed [GAIN_W-1:0]  deriv_gain;
    logic signed [LIMIT_W-1:0] out_lower_limit;
    logic signed [LIMIT_W-1:0] out_upper_limit;
    logic [MS_W-1:0]           min_speed;
  } cfg_t;

endpackage

[src/pidpmd_cfg.sv]
// ----------------------------------------------------------------------------
// pidpmd_cfg: settings registers
// Gains, output limits and minimum speed, written through a plain write port.
// ----------------------------------------------------------------------------
module pidpmd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pidpmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pidpmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pidpmd_pkg::cfg_t                   cfg
);
  import pidpmd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= PROP_GAIN_RST;
      cfg.integ_gain      <= INTEG_GAIN_RST;
      cfg.deriv_gain      <= DERIV_GAIN_RST;
      cfg.out_lower_limit <= OUT_LOWER_RST;
      cfg.out_upper_limit <= OUT_UPPER_RST;
      cfg.min_speed       <= MIN_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:  cfg.prop_gain       <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN: cfg.integ_gain      <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN: cfg.deriv_gain      <= cfg_data[GAIN_W-1:0];
        CFG_OUT_LOWER:  cfg.out_lower_limit <= cfg_data[LIMIT_W-1:0];
        CFG_OUT_UPPER:  cfg.out_upper_limit <= cfg_data[LIMIT_W-1:0];
        CFG_MIN_SPEED:  cfg.min_speed       <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/pid_position_motor_drive_core.sv]
// ----------------------------------------------------------------------------
// pid_position_motor_drive_core: position PID with anti-windup, dir/magnitude
// Registered in order: the input register, the product register (three gain
// multipliers) and the result register (integrator add/clamp, sum, clamp, min
// speed). Throughput one word per cycle while the output is not stalled; the
// integrator feedback is one add and clamp. Synchronous reset restores default
// settings, clears the integrator and previous position and arms the
// first-sample flag.
// ----------------------------------------------------------------------------
module pid_position_motor_drive_core #(
  parameter int POS_WIDTH = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // target_pos, measured_pos
  input  logic [((2*POS_WIDTH+7)/8)*8-1:0]        s_tdata,
  // clear_history
  input  logic                                    s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // drive_magnitude
  output logic [pidpmd_pkg::MAG_W-1:0]            m_tdata,
  // reverse
  output logic                                    m_tuser,
  input  logic                                    cfg_we,
  input  logic [pidpmd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidpmd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pidpmd_pkg::*;

  localparam int ERR_W  = POS_WIDTH + 1;
  localparam int PROD_W = ERR_W + GAIN_W;
  localparam int INT_W  = LIMIT_W + FRAC_BITS + 1;
  localparam int ACC_W  = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;
  localparam int SUM_W  = ACC_W + 1;

  cfg_t cfg;

  pidpmd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  logic                 in_valid;
  logic [POS_WIDTH-1:0] in_target;
  logic [POS_WIDTH-1:0] in_measured;
  logic                 in_clear;

  // product register
  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic                     prod_clear;

  // controller state
  logic signed [INT_W-1:0] integrator;
  logic [POS_WIDTH-1:0]    prev_measure;
  logic                    first_sample;

  logic out_ready, prod_ready, adv_prod, adv_out;

  assign out_ready  = !m_tvalid || m_tready;
  assign prod_ready = !prod_valid || out_ready;
  assign s_tready   = !in_valid || prod_ready;
  assign adv_prod   = in_valid && prod_ready;
  assign adv_out    = prod_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_target   <= s_tdata[POS_WIDTH-1:0];
      in_measured <= s_tdata[2*POS_WIDTH-1:POS_WIDTH];
      in_clear    <= s_tuser;
    end
  end

  // error, measurement change and the three gain products
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  dmeas;
  logic [POS_WIDTH-1:0]     prev_eff;
  logic signed [PROD_W-1:0] p_next, i_next, d_next;

  always_comb begin
    // a cleared or first sample sees no measurement change
    prev_eff = (in_clear || first_sample) ? in_measured : prev_measure;
    err      = $signed({1'b0, in_target}) - $signed({1'b0, in_measured});
    dmeas    = $signed({1'b0, in_measured}) - $signed({1'b0, prev_eff});
    p_next   = err * $signed(cfg.prop_gain);
    i_next   = err * $signed(cfg.integ_gain);
    d_next   = dmeas * $signed(cfg.deriv_gain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      prev_measure <= '0;
      first_sample <= 1'b1;
    end else begin
      if (prod_ready) begin
        prod_valid <= in_valid;
      end
      if (adv_prod) begin
        prev_measure <= in_measured;
        first_sample <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_prod) begin
      prod_p     <= p_next;
      prod_i     <= i_next;
      prod_d     <= d_next;
      prod_clear <= in_clear;
    end
  end

  // integrator update, sum, clamps and minimum speed
  logic signed [ACC_W-1:0] lo_acc, hi_acc, acc, acc_lo, acc_cl;
  logic signed [INT_W-1:0] int_base, integ_next;
  logic signed [SUM_W-1:0] lo_sum, hi_sum, ms_sum, ms_neg;
  logic signed [SUM_W-1:0] sum, sum_cl, sum_ms, abs_v;
  logic                    neg;
  logic [MAG_W-1:0]        mag;

  always_comb begin
    lo_acc = {{(ACC_W-LIMIT_W-FRAC_BITS){cfg.out_lower_limit[LIMIT_W-1]}},
              cfg.out_lower_limit, {FRAC_BITS{1'b0}}};
    hi_acc = {{(ACC_W-LIMIT_W-FRAC_BITS){cfg.out_upper_limit[LIMIT_W-1]}},
              cfg.out_upper_limit, {FRAC_BITS{1'b0}}};
    lo_sum = {{(SUM_W-LIMIT_W-FRAC_BITS){cfg.out_lower_limit[LIMIT_W-1]}},
              cfg.out_lower_limit, {FRAC_BITS{1'b0}}};
    hi_sum = {{(SUM_W-LIMIT_W-FRAC_BITS){cfg.out_upper_limit[LIMIT_W-1]}},
              cfg.out_upper_limit, {FRAC_BITS{1'b0}}};
    ms_sum = {{(SUM_W-MS_W-FRAC_BITS){1'b0}}, cfg.min_speed, {FRAC_BITS{1'b0}}};
    ms_neg = -ms_sum;

    int_base = prod_clear ? '0 : integrator;
    acc      = ACC_W'(int_base) + ACC_W'(prod_i);
    // lower clamp first, then upper
    acc_lo     = (acc < lo_acc) ? lo_acc : acc;
    acc_cl     = (acc_lo > hi_acc) ? hi_acc : acc_lo;
    integ_next = acc_cl[INT_W-1:0];

    sum = SUM_W'(prod_p) + SUM_W'(integ_next) - SUM_W'(prod_d);
    if (sum < lo_sum) begin
      sum_cl = lo_sum;
    end else if (sum > hi_sum) begin
      sum_cl = hi_sum;
    end else begin
      sum_cl = sum;
    end

    neg = sum_cl[SUM_W-1];
    if (neg && (sum_cl > ms_neg)) begin
      sum_ms = ms_neg;
    end else if (!neg && (sum_cl != '0) && (sum_cl < ms_sum)) begin
      sum_ms = ms_sum;
    end else begin
      sum_ms = sum_cl;
    end

    abs_v = neg ? -sum_ms : sum_ms;
    mag   = abs_v[FRAC_BITS+MAG_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      integrator <= '0;
    end else begin
      if (out_ready) begin
        m_tvalid <= prod_valid;
      end
      if (adv_out) begin
        integrator <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      m_tdata <= mag;
      m_tuser <= neg;
    end
  end

endmodule

[src/pidpmd_checker.sv]
// ----------------------------------------------------------------------------
// pidpmd_checker: port-level checks of the position PID drive
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module pidpmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pidpmd_pkg::MAG_W-1:0]  m_tdata,
  input logic                          m_tuser
);
  import pidpmd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // input stalls only when every stage is full and the output is blocked
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result word right after reset");

  // forward drive never exceeds the largest positive limit
  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !m_tdata[MAG_W-1])
    else $error("forward magnitude out of range");

endmodule

bind pid_position_motor_drive_core pidpmd_checker u_pidpmd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for pid_position_motor_drive_core
// Streams setpoint/position words into the core under several gain, limit and
// min-speed settings and compares every drive word with a cycle-free model of
// the PID law kept in a small scoreboard. Directed corner words come first,
// then tracking-style random words, most with random back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb;
  import pidpmd_pkg::*;

  localparam int FRAC       = 8;
  localparam int CYCLE_CAP  = 400000;
  localparam int WORDS_EACH = 140;

  typedef struct {
    logic [MAG_W-1:0] mag;
    logic             rev;
  } drive_t;

  // Holds the controller state and the settings, predicts one drive word per
  // accepted input word and checks the core's words against that queue.
  class drive_scoreboard;
    longint kp, ki, kd, lo_lim, hi_lim, min_spd;
    longint integ_acc;
    longint last_meas;
    bit     first_pt;
    int     errors;
    drive_t expected_drive[$];

    function new();
      kp      = longint'(PROP_GAIN_RST);
      ki      = longint'(INTEG_GAIN_RST);
      kd      = longint'(DERIV_GAIN_RST);
      lo_lim  = longint'(OUT_LOWER_RST);
      hi_lim  = longint'(OUT_UPPER_RST);
      min_spd = longint'(MIN_SPEED_RST);
      errors  = 0;
      clear_history();
    endfunction

    function void clear_history();
      integ_acc = 0;
      last_meas = 0;
      first_pt  = 1'b1;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PROP_GAIN:  kp = longint'($signed(val));
        CFG_INTEG_GAIN: ki = longint'($signed(val));
        CFG_DERIV_GAIN: kd = longint'($signed(val));
        CFG_OUT_LOWER:  lo_lim = longint'($signed(val));
        CFG_OUT_UPPER:  hi_lim = longint'($signed(val));
        CFG_MIN_SPEED:  min_spd = longint'(val[MS_W-1:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    function void note_input(logic [15:0] tgt, logic [15:0] meas, logic clr);
      longint lo, hi, ms, err, dmeas, sum, mag;
      drive_t d;
      lo = lo_lim <<< FRAC;
      hi = hi_lim <<< FRAC;
      ms = min_spd <<< FRAC;
      if (clr) clear_history();
      err = longint'(tgt) - longint'(meas);
      // integrator clamps lower first, then upper, so crossed limits end at upper
      integ_acc += err * ki;
      if (integ_acc < lo) integ_acc = lo;
      if (integ_acc > hi) integ_acc = hi;
      if (first_pt) begin
        first_pt  = 1'b0;
        last_meas = longint'(meas);
      end
      dmeas = longint'(meas) - last_meas;
      last_meas = longint'(meas);
      sum = err * kp + integ_acc - dmeas * kd;
      if (sum < lo) sum = lo;
      else if (sum > hi) sum = hi;
      d.rev = (sum < 0);
      if (d.rev && sum > -ms) sum = -ms;
      else if (sum > 0 && sum < ms) sum = ms;
      mag = d.rev ? -sum : sum;
      mag = mag >> FRAC;
      d.mag = mag[MAG_W-1:0];
      expected_drive.push_back(d);
    endfunction

    function void check_result(logic [MAG_W-1:0] mag, logic rev);
      drive_t d;
      if (expected_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected drive word, got mag %0d rev %0d", $time, mag, rev);
        return;
      end
      d = expected_drive.pop_front();
      if (mag !== d.mag) begin
        errors++;
        $display("%0t: drive_magnitude expected %0d actual %0d", $time, d.mag, mag);
      end
      if (rev !== d.rev) begin
        errors++;
        $display("%0t: reverse expected %0d actual %0d", $time, d.rev, rev);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [MAG_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int              send_idle = 0;
  int              recv_idle = 0;
  int              cycles = 0;
  logic [15:0]     track_pos = 16'd30000;
  drive_scoreboard sb = new();

  pid_position_motor_drive_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata[15:0], s_tdata[31:16], s_tuser);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("pid_position_motor_drive_core: mismatch");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [15:0] tgt, logic [15:0] meas, logic clr);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {meas, tgt};
    s_tuser  <= clr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every drive word is back and the pipe is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                logic [15:0] lo, logic [15:0] hi, logic [15:0] ms);
    cfg_idx_t idx;
    logic [15:0] vals [6];
    vals = '{kp, ki, kd, lo, hi, ms};
    for (int i = 0; i < 6; i++) begin
      idx = cfg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      sb.set_reg(idx, vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1024)) - 16'd512;
    endcase
  endfunction

  task automatic apply_random_settings();
    logic [15:0] lo, hi, ms;
    case ($urandom_range(9))
      0: begin
        lo = 16'h8000;
        hi = 16'h7FFF;
      end
      1: begin
        // crossed limits
        lo = 16'($urandom_range(500, 1));
        hi = -16'($urandom_range(500, 1));
      end
      default: begin
        lo = -16'($urandom_range(2000));
        hi = 16'($urandom_range(2000));
      end
    endcase
    case ($urandom_range(9))
      0:       ms = 16'h7FFF;
      1:       ms = 16'($urandom_range(32767));
      2, 3, 4: ms = 16'($urandom_range(50));
      default: ms = 16'h0000;
    endcase
    apply_settings(rand_gain(), rand_gain(), rand_gain(), lo, hi, ms);
  endtask

  // Mostly a slowly moving axis with a nearby setpoint; some full-range noise.
  task automatic send_random_word();
    logic [15:0] tgt, meas;
    logic clr;
    clr = ($urandom_range(19) == 0);
    case ($urandom_range(9))
      7: begin
        tgt  = 16'($urandom);
        meas = 16'($urandom);
      end
      8: begin
        track_pos = track_pos + 16'($urandom_range(40)) - 16'd20;
        meas = track_pos;
        tgt  = track_pos;
      end
      9: begin
        tgt  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        meas = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        track_pos = track_pos + 16'($urandom_range(40)) - 16'd20;
        meas = track_pos;
        tgt  = track_pos + 16'($urandom_range(400)) - 16'd200;
      end
    endcase
    send_word(tgt, meas, clr);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: first sample, both clamps, plain proportional
    send_word(16'd0, 16'd0, 1'b0);
    send_word(16'hFFFF, 16'd0, 1'b0);
    send_word(16'd0, 16'hFFFF, 1'b0);
    send_word(16'd1000, 16'd990, 1'b0);

    // fractional result truncates to zero magnitude
    drain();
    apply_settings(16'd1, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'd0);
    send_word(16'd100, 16'd0, 1'b0);
    send_word(16'd0, 16'd100, 1'b0);

    // min speed lifts small results, not a zero one
    drain();
    apply_settings(16'd1, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'd5);
    send_word(16'd100, 16'd0, 1'b0);
    send_word(16'd0, 16'd100, 1'b0);
    send_word(16'd7, 16'd7, 1'b0);

    // extreme gains, full limits
    drain();
    apply_settings(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_word(16'hFFFF, 16'd0, 1'b1);
    send_word(16'd0, 16'hFFFF, 1'b0);
    send_word(16'd32768, 16'd32768, 1'b0);

    drain();
    apply_settings(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);
    send_word(16'hFFFF, 16'd0, 1'b0);
    send_word(16'd0, 16'hFFFF, 1'b0);
    send_word(16'd1, 16'd2, 1'b1);

    // crossed limits
    drain();
    apply_settings(16'd256, 16'd128, 16'd64, 16'd50, -16'd50, 16'd0);
    send_word(16'd10, 16'd0, 1'b1);
    send_word(16'd0, 16'd10, 1'b0);
    send_word(16'd0, 16'd0, 1'b0);

    // derivative on measurement, restarted by clear
    drain();
    apply_settings(16'd0, 16'd0, 16'd256, -16'd1000, 16'd1000, 16'd0);
    send_word(16'd0, 16'd100, 1'b1);
    send_word(16'd0, 16'd110, 1'b0);
    send_word(16'd0, 16'd90, 1'b1);
    send_word(16'd0, 16'd95, 1'b0);

    // integrator windup against the limits
    drain();
    apply_settings(16'd0, 16'd256, 16'd0, -16'd20, 16'd20, 16'd0);
    send_word(16'd100, 16'd0, 1'b0);
    send_word(16'd0, 16'd10, 1'b0);
    send_word(16'd0, 16'd0, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 32 : (mode == 1) ? 59 : 0;
      recv_idle = (mode == 0) ? 59 : (mode == 1) ? 32 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        drain();
        apply_random_settings();
        for (int i = 0; i < WORDS_EACH; i++) begin
          if (blk == 0 && i == WORDS_EACH / 2) drain();
          send_random_word();
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pid_position_motor_drive_core: match");
    end else begin
      $display("pid_position_motor_drive_core: mismatch");
    end
    $finish;
  end

endmodule
